// ----- rtl/core/ufem_pkg.sv -----
// Shared types and constants of the union-find edge merger.
package ufem_pkg;

  localparam int COORD_W         = 6;
  localparam int ROW_WIDTH_W     = 7;
  localparam int MAX_ROW_WIDTH_D = 64;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(64);
  localparam int COORD_MAX       = (1 << COORD_W) - 1;
  localparam int ROW_WIDTH_MAX   = (1 << ROW_WIDTH_W) - 1;
  // Largest raw node index before reduction: col + row * row_width.
  localparam int RAW_MAX         = COORD_MAX + COORD_MAX * ROW_WIDTH_MAX;
  localparam int RAW_W           = $clog2(RAW_MAX + 1);

  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_INIT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
    logic [COORD_W-1:0] to_row;
    logic [COORD_W-1:0] to_col;
  } ufem_in_t;

  typedef struct packed {
    logic               joined;
    logic [COORD_W-1:0] mid_row;
    logic [COORD_W-1:0] mid_col;
  } ufem_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_REDUCE,
    ST_FIND_RD,
    ST_FIND,
    ST_COMPRESS,
    ST_NEXT
  } ufem_state_t;

endpackage

// ----- rtl/core/ufem_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module ufem_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/union_find_edge_merger_core.sv -----
// Top level of the union-find edge merger: sequencer, index unit and parent table.
//
// Usage: a request word is taken on in_word at a rising edge where start is
// high and busy is low. An edge request names a from cell and a to cell; the
// block maps each cell to node col + row * row_width (wrapped into the
// table), finds both roots with path compression and links the from root
// under the to root when they differ. Exactly one result word comes back on
// out_word, valid for one cycle while out_strobe is high; the strobe rises
// in the same cycle in which busy falls. The receiver cannot stall the block.
// Course of an edge: per endpoint an index step, STEPS reduce steps (1 at
// the default size), a table read, one find step per parent hop plus one
// that sees the root, one write per compressed entry and a closing step.
// The rate is set by the single read port of the parent table, which the walk
// uses once per hop. An init request rewrites the whole table, one entry a
// cycle. After reset the same clearing pass runs with busy high and no result
// word; row_width resets to 64. row_width is written via cfg_we / cfg_data;
// the user must write it only while no request is in flight, as the block
// itself does not enforce this.
module union_find_edge_merger_core
  import ufem_pkg::*;
#(
  parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_D
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  ufem_in_t               in_word,
  output logic                   out_strobe,
  output ufem_out_t              out_word,
  input  logic                   cfg_we,
  input  logic [ROW_WIDTH_W-1:0] cfg_data
);

  // Table geometry and the constants of the remainder unit.
  localparam int TBL     = MAX_ROW_WIDTH * MAX_ROW_WIDTH;
  localparam int IDX_W   = $clog2(TBL);
  localparam int Q_MAX   = RAW_MAX / TBL;
  localparam int STEPS   = (Q_MAX == 0) ? 1 : $clog2(Q_MAX + 1);
  localparam int DIV_TOP = TBL << (STEPS - 1);
  localparam int RED_W   = $clog2(((RAW_MAX > DIV_TOP) ? RAW_MAX : DIV_TOP) + 1);
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

  ufem_state_t             state_r, state_nxt;
  ufem_in_t                in_r, in_nxt;
  logic [ROW_WIDTH_W-1:0]  row_width_r;
  logic                    phase_r, phase_nxt;
  logic [RED_W-1:0]        red_r, red_nxt;
  logic [RED_W-1:0]        div_r, div_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [IDX_W-1:0]        node_r, node_nxt;
  logic [IDX_W-1:0]        root_r, root_nxt;
  logic [IDX_W-1:0]        from_root_r, from_root_nxt;
  logic [IDX_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic                    clr_report_r, clr_report_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  ufem_out_t               out_word_r, out_word_nxt;

  // Parent table port signals.
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [IDX_W-1:0]        ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [IDX_W-1:0]        ram_rdata;

  // Index datapath: one small multiply, then a shared compare-subtract.
  logic [COORD_W-1:0]      sel_row, sel_col;
  logic [RAW_W-1:0]        raw_idx;
  logic                    red_ge;
  logic [RED_W-1:0]        red_sub;
  logic [COORD_W:0]        sum_row, sum_col;

  ufem_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TBL)
  ) u_parent (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign sel_row = phase_r ? in_r.to_row : in_r.from_row;
  assign sel_col = phase_r ? in_r.to_col : in_r.from_col;
  assign raw_idx = RAW_W'(sel_col) + RAW_W'(RAW_W'(sel_row) * RAW_W'(row_width_r));
  assign red_ge  = (red_r >= div_r);
  assign red_sub = red_ge ? (red_r - div_r) : red_r;
  assign sum_row = {1'b0, in_r.from_row} + {1'b0, in_r.to_row};
  assign sum_col = {1'b0, in_r.from_col} + {1'b0, in_r.to_col};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      out_strobe_r <= 1'b0;
      row_width_r  <= ROW_WIDTH_RST;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_report_r <= clr_report_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        row_width_r <= cfg_data;
      end
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    phase_r     <= phase_nxt;
    red_r       <= red_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    cur_r       <= cur_nxt;
    node_r      <= node_nxt;
    root_r      <= root_nxt;
    from_root_r <= from_root_nxt;
    out_word_r  <= out_word_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    phase_nxt      = phase_r;
    red_nxt        = red_r;
    div_nxt        = div_r;
    step_nxt       = step_r;
    cur_nxt        = cur_r;
    node_nxt       = node_r;
    root_nxt       = root_r;
    from_root_nxt  = from_root_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_report_nxt = clr_report_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = root_r;
    ram_raddr      = cur_r;

    case (state_r)
      // Sweep the table so that every node is its own parent.
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(TBL - 1)) begin
          clr_cnt_nxt    = '0;
          state_nxt      = ST_IDLE;
          out_strobe_nxt = clr_report_r;
          out_word_nxt   = '0;
        end
      end

      ST_IDLE: begin
        if (start) begin
          in_nxt    = in_word;
          phase_nxt = 1'b0;
          if (in_word.req_type == REQ_INIT) begin
            clr_cnt_nxt    = '0;
            clr_report_nxt = 1'b1;
            state_nxt      = ST_CLEAR;
          end else begin
            state_nxt = ST_INDEX;
          end
        end
      end

      ST_INDEX: begin
        red_nxt   = RED_W'(raw_idx);
        div_nxt   = RED_W'(DIV_TOP);
        step_nxt  = '0;
        state_nxt = ST_REDUCE;
      end

      // Remainder by the table size, one quotient bit per cycle.
      ST_REDUCE: begin
        red_nxt  = red_sub;
        div_nxt  = div_r >> 1;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          cur_nxt   = red_sub[IDX_W-1:0];
          node_nxt  = red_sub[IDX_W-1:0];
          state_nxt = ST_FIND_RD;
        end
      end

      ST_FIND_RD: begin
        ram_raddr = cur_r;
        state_nxt = ST_FIND;
      end

      // ram_rdata holds the parent of cur_r; follow it until a root shows.
      ST_FIND: begin
        if (ram_rdata != cur_r) begin
          cur_nxt   = ram_rdata;
          ram_raddr = ram_rdata;
        end else begin
          root_nxt = cur_r;
          if (node_r != cur_r) begin
            cur_nxt   = node_r;
            ram_raddr = node_r;
            state_nxt = ST_COMPRESS;
          end else begin
            state_nxt = ST_NEXT;
          end
        end
      end

      // Point each entry of the path at the root while reading the next one.
      ST_COMPRESS: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = root_r;
        cur_nxt   = ram_rdata;
        ram_raddr = ram_rdata;
        if (ram_rdata == root_r) begin
          state_nxt = ST_NEXT;
        end
      end

      ST_NEXT: begin
        if (!phase_r) begin
          from_root_nxt = root_r;
          phase_nxt     = 1'b1;
          state_nxt     = ST_INDEX;
        end else begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '0;
          if (from_root_r != root_r) begin
            ram_we               = 1'b1;
            ram_waddr            = from_root_r;
            ram_wdata            = root_r;
            out_word_nxt.joined  = 1'b1;
            out_word_nxt.mid_row = sum_row[COORD_W:1];
            out_word_nxt.mid_col = sum_col[COORD_W:1];
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy)
    else $error("parent table written while idle");

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n)) |-> $past(busy))
    else $error("result word without a request in flight");

  a_join_roots: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.joined && $past(rst_n)) |-> $past(from_root_r != root_r))
    else $error("edge reported joined with equal roots");
`endif

endmodule
